>>> hdl/sfts_pkg.sv
// ----------------------------------------------------------------------------
// sfts_pkg: shared types and constants for the swing foot trajectory step
// Holds configuration and request types, the pipeline sideband records, the
// angle constants in Q.30, the CORDIC arctangent table and result saturation.
// ----------------------------------------------------------------------------
package sfts_pkg;

  // Configuration register indexes
  localparam logic [2:0] CFG_GAIN_LIN = 3'd0;
  localparam logic [2:0] CFG_GAIN_YAW = 3'd1;
  localparam logic [2:0] CFG_TICK     = 3'd2;
  localparam logic [2:0] CFG_STANCE   = 3'd3;
  localparam logic [2:0] CFG_SWING    = 3'd4;
  localparam logic [2:0] CFG_LIFT     = 3'd5;

  // Angle constants, Q.30 radians
  localparam logic signed [33:0] PI_Q30        = 34'sd3373259426;
  localparam logic signed [33:0] HALF_PI_Q30   = 34'sd1686629713;
  localparam logic signed [33:0] TWO_PI_Q30    = 34'sd6746518852;
  localparam logic signed [33:0] TWO_PI_M_HALF = 34'sd5059889139;
  localparam logic signed [31:0] CORDIC_GAIN   = 32'sd652032874;

  // 2^52 / TWO_PI_Q30, estimates the number of turns in an angle
  localparam logic [19:0] TURN_RECIP = 20'd667544;

  // Table length and quotient bits below the saturation point
  localparam int unsigned ATAN_LEN = 20;
  localparam int unsigned QUOT_W   = 18;

  typedef struct packed {
    logic [15:0] gain_lin;
    logic [15:0] gain_yaw;
    logic [15:0] tick;
    logic [9:0]  stance_cnt;
    logic [9:0]  swing_cnt;
    logic [14:0] lift_h;
  } cfg_t;

  typedef struct packed {
    logic [16:0] phase;
    logic [15:0] foot_x;
    logic [15:0] foot_y;
    logic [15:0] vel_x;
    logic [15:0] vel_y;
    logic [15:0] yaw_cmd;
    logic [15:0] body_height;
    logic [15:0] stance_x;
    logic [15:0] stance_y;
  } req_t;

  // Sideband that travels with the angle through the rotation
  typedef struct packed {
    logic [16:0] phase;
    logic [15:0] foot_x;
    logic [15:0] foot_y;
    logic [15:0] stance_x;
    logic [15:0] stance_y;
    logic [58:0] lin_vx;
    logic [58:0] lin_vy;
    logic [17:0] nz;
    logic        flip;
  } side_t;

  // Sideband that travels with one lane through the divider
  typedef struct packed {
    logic [15:0] foot;
    logic [28:0] td;
    logic        neg;
    logic        zero;
    logic [17:0] nz;
  } div_side_t;

  function automatic logic [31:0] atan_q30(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'h3243F6A8;
      5'd1:  v = 32'h1DAC6705;
      5'd2:  v = 32'h0FADBAFC;
      5'd3:  v = 32'h07F56EA6;
      5'd4:  v = 32'h03FEAB76;
      5'd5:  v = 32'h01FFD55B;
      5'd6:  v = 32'h00FFFAAA;
      5'd7:  v = 32'h007FFF55;
      5'd8:  v = 32'h003FFFEA;
      5'd9:  v = 32'h001FFFFD;
      5'd10: v = 32'h000FFFFF;
      5'd11: v = 32'h0007FFFF;
      5'd12: v = 32'h0003FFFF;
      5'd13: v = 32'h0001FFFF;
      5'd14: v = 32'h0000FFFF;
      5'd15: v = 32'h00007FFF;
      5'd16: v = 32'h00003FFF;
      5'd17: v = 32'h00001FFF;
      5'd18: v = 32'h00000FFF;
      5'd19: v = 32'h000007FF;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

  function automatic logic [15:0] sat16(input logic signed [29:0] v);
    logic [15:0] r;
    if (v > 30'sd32767) begin
      r = 16'h7FFF;
    end else if (v < -30'sd32768) begin
      r = 16'h8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

>>> hdl/sfts_front.sv
// ----------------------------------------------------------------------------
// sfts_front: gain products, yaw angle, angle reduction and fold
// Eight stages: time scale, gains, angle and velocity offsets, rounding to
// Q.30, turn estimate, remainder, correction into one turn, fold to +-pi/2.
// ----------------------------------------------------------------------------
module sfts_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  sfts_pkg::req_t       req_i,
  input  sfts_pkg::cfg_t       cfg_i,
  output logic                 valid_o,
  output logic signed [31:0]   ang_o,
  output sfts_pkg::side_t      side_o
);

  localparam logic signed [33:0] TWO_PI_Q30_W = sfts_pkg::TWO_PI_Q30;

  logic [7:0] v_q;

  // Stage 1 combinational: clamp phase, lift profile, time scale
  logic [16:0]        phase_c;
  logic [16:0]        lift_span;
  logic [31:0]        lift_prod;
  logic [32:0]        lift_rnd;
  logic signed [17:0] nz_c;
  sfts_pkg::req_t     req_c;

  assign phase_c   = (req_i.phase > 17'd65536) ? 17'd65536 : req_i.phase;
  assign lift_span = (phase_c < 17'd32768) ? phase_c : (17'd65536 - phase_c);
  assign lift_prod = lift_span * cfg_i.lift_h;
  assign lift_rnd  = {1'b0, lift_prod} + 33'd16384;
  assign nz_c      = $signed({2'b00, lift_rnd[30:15]})
                   + $signed({{2{req_i.body_height[15]}}, req_i.body_height});

  // Carry the request with the clamped phase
  always_comb begin
    req_c       = req_i;
    req_c.phase = phase_c;
  end

  sfts_pkg::req_t    req1_q, req2_q;
  logic [17:0]       nz1_q, nz2_q;
  logic [25:0]       ts1_q;
  logic [41:0]       lin2_q, yts2_q;
  logic signed [58:0] ang3_q;
  logic signed [46:0] a30_4_q, a30_5_q;
  logic signed [47:0] qp5_q;
  logic signed [36:0] r6_q, r7_q;
  logic signed [31:0] ang8_q;
  sfts_pkg::side_t   side3_q, side4_q, side5_q, side6_q, side7_q, side8_q;

  // Stage 3 combinational products
  logic signed [58:0] ang_c, linvx_c, linvy_c;
  assign ang_c   = $signed({1'b0, yts2_q}) * $signed(req2_q.yaw_cmd);
  assign linvx_c = $signed({1'b0, lin2_q}) * $signed(req2_q.vel_x);
  assign linvy_c = $signed({1'b0, lin2_q}) * $signed(req2_q.vel_y);

  // Stage 4: round half up to Q.30
  logic signed [58:0] ang_rnd;
  assign ang_rnd = ang3_q + 59'sd2048;

  // Stage 5: turn estimate from the upper angle bits
  logic signed [26:0] ang_hi;
  assign ang_hi = a30_4_q[46:20];

  // Stage 6: remainder after the estimated number of turns
  logic signed [15:0] turns;
  logic signed [49:0] turn_prod;
  logic signed [49:0] rem_full;
  assign turns     = qp5_q[47:32];
  assign turn_prod = turns * TWO_PI_Q30_W;
  assign rem_full  = {{3{a30_5_q[46]}}, a30_5_q} - turn_prod;

  // Stage 7: bring the remainder into one turn
  logic signed [36:0] r7_c;
  always_comb begin
    if (r6_q < 37'sd0) begin
      r7_c = r6_q + sfts_pkg::TWO_PI_Q30;
    end else if (r6_q >= sfts_pkg::TWO_PI_Q30) begin
      r7_c = r6_q - sfts_pkg::TWO_PI_Q30;
    end else begin
      r7_c = r6_q;
    end
  end

  // Stage 8: fold into +-pi/2, flip marks a half turn taken out
  logic signed [36:0] fold_c;
  logic               flip_c;
  always_comb begin
    if (r7_q <= sfts_pkg::HALF_PI_Q30) begin
      fold_c = r7_q;
      flip_c = 1'b0;
    end else if (r7_q < sfts_pkg::TWO_PI_M_HALF) begin
      fold_c = r7_q - sfts_pkg::PI_Q30;
      flip_c = 1'b1;
    end else begin
      fold_c = r7_q - sfts_pkg::TWO_PI_Q30;
      flip_c = 1'b0;
    end
  end

  // Mark the sideband with the fold flip
  sfts_pkg::side_t side8_c;
  always_comb begin
    side8_c      = side7_q;
    side8_c.flip = flip_c;
  end

  // Advance the valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[6:0], valid_i};
    end
  end

  // Advance the payload
  always_ff @(posedge clk_i) begin
    req1_q       <= req_c;
    nz1_q        <= nz_c;
    ts1_q        <= cfg_i.stance_cnt * cfg_i.tick;

    req2_q <= req1_q;
    nz2_q  <= nz1_q;
    lin2_q <= cfg_i.gain_lin * ts1_q;
    yts2_q <= cfg_i.gain_yaw * ts1_q;

    ang3_q          <= ang_c;
    side3_q.phase    <= req2_q.phase;
    side3_q.foot_x   <= req2_q.foot_x;
    side3_q.foot_y   <= req2_q.foot_y;
    side3_q.stance_x <= req2_q.stance_x;
    side3_q.stance_y <= req2_q.stance_y;
    side3_q.lin_vx   <= linvx_c;
    side3_q.lin_vy   <= linvy_c;
    side3_q.nz       <= nz2_q;
    side3_q.flip     <= 1'b0;

    a30_4_q <= ang_rnd[58:12];
    side4_q <= side3_q;

    qp5_q   <= ang_hi * $signed({1'b0, sfts_pkg::TURN_RECIP});
    a30_5_q <= a30_4_q;
    side5_q <= side4_q;

    r6_q    <= rem_full[36:0];
    side6_q <= side5_q;

    r7_q    <= r7_c;
    side7_q <= side6_q;

    ang8_q       <= fold_c[31:0];
    side8_q      <= side8_c;
  end

  assign valid_o = v_q[7];
  assign ang_o   = ang8_q;
  assign side_o  = side8_q;

endmodule

>>> hdl/sfts_cordic.sv
// ----------------------------------------------------------------------------
// sfts_cordic: pipelined CORDIC rotation for cos and sin
// One rotation step per stage with a fixed gain start vector, then one
// stage that applies the half turn flip from the fold.
// ----------------------------------------------------------------------------
module sfts_cordic #(
  parameter int unsigned STEPS = 14
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic signed [31:0]   ang_i,
  input  sfts_pkg::side_t      side_i,
  output logic                 valid_o,
  output logic signed [31:0]   cos_o,
  output logic signed [31:0]   sin_o,
  output sfts_pkg::side_t      side_o
);

  logic                v_q    [STEPS];
  logic signed [31:0]  x_q    [STEPS];
  logic signed [31:0]  y_q    [STEPS];
  logic signed [31:0]  z_q    [STEPS];
  sfts_pkg::side_t     side_q [STEPS];

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic               v_in;
    logic signed [31:0] x_in, y_in, z_in;
    sfts_pkg::side_t    s_in;
    logic signed [31:0] atan_v;

    if (i == 0) begin : g_first
      assign v_in = valid_i;
      assign x_in = sfts_pkg::CORDIC_GAIN;
      assign y_in = 32'sd0;
      assign z_in = ang_i;
      assign s_in = side_i;
    end else begin : g_next
      assign v_in = v_q[i-1];
      assign x_in = x_q[i-1];
      assign y_in = y_q[i-1];
      assign z_in = z_q[i-1];
      assign s_in = side_q[i-1];
    end

    assign atan_v = $signed(sfts_pkg::atan_q30(5'(i)));

    // Advance the valid bit
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else begin
        v_q[i] <= v_in;
      end
    end

    // Rotate toward zero residual angle
    always_ff @(posedge clk_i) begin
      side_q[i] <= s_in;
      if (z_in >= 32'sd0) begin
        x_q[i] <= x_in - (y_in >>> i);
        y_q[i] <= y_in + (x_in >>> i);
        z_q[i] <= z_in - atan_v;
      end else begin
        x_q[i] <= x_in + (y_in >>> i);
        y_q[i] <= y_in - (x_in >>> i);
        z_q[i] <= z_in + atan_v;
      end
    end
  end

  logic               vo_q;
  logic signed [31:0] cos_q, sin_q;
  sfts_pkg::side_t    so_q;

  // Apply the half turn flip
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else begin
      vo_q <= v_q[STEPS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    so_q  <= side_q[STEPS-1];
    cos_q <= side_q[STEPS-1].flip ? -x_q[STEPS-1] : x_q[STEPS-1];
    sin_q <= side_q[STEPS-1].flip ? -y_q[STEPS-1] : y_q[STEPS-1];
  end

  assign valid_o = vo_q;
  assign cos_o   = cos_q;
  assign sin_o   = sin_q;
  assign side_o  = so_q;

endmodule

>>> hdl/sfts_divider.sv
// ----------------------------------------------------------------------------
// sfts_divider: pipelined restoring divider with saturating quotient
// One stage flags quotients at or above 2^QUOT_W, then one quotient bit per
// stage, most significant first.
// ----------------------------------------------------------------------------
module sfts_divider (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  logic [46:0]              num_i,
  input  logic [26:0]              den_i,
  input  sfts_pkg::div_side_t      side_i,
  output logic                     valid_o,
  output logic [sfts_pkg::QUOT_W:0] quot_o,
  output sfts_pkg::div_side_t      side_o
);

  localparam int unsigned QW = sfts_pkg::QUOT_W;

  logic                v0_q;
  logic                ovf0_q;
  logic [46:0]         num0_q;
  logic [26:0]         den0_q;
  sfts_pkg::div_side_t side0_q;

  // Flag quotients that saturate
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ovf0_q  <= num_i >= 47'({den_i, {QW{1'b0}}});
    num0_q  <= num_i;
    den0_q  <= den_i;
    side0_q <= side_i;
  end

  logic                v_q    [QW];
  logic                ovf_q  [QW];
  logic [46:0]         num_q  [QW];
  logic [26:0]         den_q  [QW];
  logic [QW-1:0]       quo_q  [QW];
  sfts_pkg::div_side_t side_q [QW];

  for (genvar j = 0; j < QW; j++) begin : g_bit
    logic                v_in, ovf_in;
    logic [46:0]         num_in, trial;
    logic [26:0]         den_in;
    logic [QW-1:0]       quo_in;
    sfts_pkg::div_side_t s_in;

    if (j == 0) begin : g_first
      assign v_in   = v0_q;
      assign ovf_in = ovf0_q;
      assign num_in = num0_q;
      assign den_in = den0_q;
      assign quo_in = '0;
      assign s_in   = side0_q;
    end else begin : g_next
      assign v_in   = v_q[j-1];
      assign ovf_in = ovf_q[j-1];
      assign num_in = num_q[j-1];
      assign den_in = den_q[j-1];
      assign quo_in = quo_q[j-1];
      assign s_in   = side_q[j-1];
    end

    assign trial = 47'(den_in) << (QW - 1 - j);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else begin
        v_q[j] <= v_in;
      end
    end

    // Subtract the shifted divisor where it fits
    always_ff @(posedge clk_i) begin
      ovf_q[j]  <= ovf_in;
      den_q[j]  <= den_in;
      side_q[j] <= s_in;
      if (num_in >= trial) begin
        num_q[j] <= num_in - trial;
        quo_q[j] <= {quo_in[QW-2:0], 1'b1};
      end else begin
        num_q[j] <= num_in;
        quo_q[j] <= {quo_in[QW-2:0], 1'b0};
      end
    end
  end

  assign valid_o = v_q[QW-1];
  assign quot_o  = ovf_q[QW-1] ? {1'b1, {QW{1'b0}}} : {1'b0, quo_q[QW-1]};
  assign side_o  = side_q[QW-1];

endmodule

>>> hdl/swing_foot_trajectory_step.sv
// ----------------------------------------------------------------------------
// swing_foot_trajectory_step: Raibert swing foot update, fully pipelined
// Touchdown point from rotated stance plus velocity offset, one tick step of
// foot xy toward it, triangular lift plus body height in z.
// ----------------------------------------------------------------------------
// The block takes a new request in every clock cycle and busy_o is always
// low. Each request gives exactly one result, shown for one cycle with
// result_valid_o, after 8 stages of angle products and reduction, one stage
// per CORDIC rotation (CORDIC_STEPS capped at 20) plus one for the sign fold,
// 4 stages for the touchdown point and the remaining swing time, 19 stages of
// the bit per stage divider and one output register. Results cannot be held
// off, so the pipeline never stalls.
// Configuration writes take effect at once and are meant for idle periods.
module swing_foot_trajectory_step #(
  parameter int unsigned CORDIC_STEPS = 14
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic [16:0] swing_phase_i,
  input  logic [15:0] foot_x_i,
  input  logic [15:0] foot_y_i,
  input  logic [15:0] vel_x_i,
  input  logic [15:0] vel_y_i,
  input  logic [15:0] yaw_cmd_i,
  input  logic [15:0] body_height_i,
  input  logic [15:0] stance_x_i,
  input  logic [15:0] stance_y_i,
  output logic        result_valid_o,
  output logic [15:0] next_x_o,
  output logic [15:0] next_y_o,
  output logic [15:0] next_z_o
);

  localparam int unsigned STEPS_EFF =
    (CORDIC_STEPS > sfts_pkg::ATAN_LEN) ? sfts_pkg::ATAN_LEN : CORDIC_STEPS;
  localparam int unsigned QW = sfts_pkg::QUOT_W;

  assign busy_o = 1'b0;

  // Hold configuration registers
  sfts_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_lin   <= 16'd8192;
      cfg_q.gain_yaw   <= 16'd8192;
      cfg_q.tick       <= 16'd655;
      cfg_q.stance_cnt <= 10'd120;
      cfg_q.swing_cnt  <= 10'd60;
      cfg_q.lift_h     <= 15'd287;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sfts_pkg::CFG_GAIN_LIN: cfg_q.gain_lin   <= cfg_wdata_i;
        sfts_pkg::CFG_GAIN_YAW: cfg_q.gain_yaw   <= cfg_wdata_i;
        sfts_pkg::CFG_TICK:     cfg_q.tick       <= cfg_wdata_i;
        sfts_pkg::CFG_STANCE:   cfg_q.stance_cnt <= cfg_wdata_i[9:0];
        sfts_pkg::CFG_SWING:    cfg_q.swing_cnt  <= cfg_wdata_i[9:0];
        sfts_pkg::CFG_LIFT:     cfg_q.lift_h     <= cfg_wdata_i[14:0];
        default: ;
      endcase
    end
  end

  // Gather the request
  sfts_pkg::req_t req;
  assign req.phase       = swing_phase_i;
  assign req.foot_x      = foot_x_i;
  assign req.foot_y      = foot_y_i;
  assign req.vel_x       = vel_x_i;
  assign req.vel_y       = vel_y_i;
  assign req.yaw_cmd     = yaw_cmd_i;
  assign req.body_height = body_height_i;
  assign req.stance_x    = stance_x_i;
  assign req.stance_y    = stance_y_i;

  logic               fr_valid;
  logic signed [31:0] fr_ang;
  sfts_pkg::side_t    fr_side;

  sfts_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_i),
    .req_i   (req),
    .cfg_i   (cfg_q),
    .valid_o (fr_valid),
    .ang_o   (fr_ang),
    .side_o  (fr_side)
  );

  logic               co_valid;
  logic signed [31:0] co_cos, co_sin;
  sfts_pkg::side_t    co_side;

  sfts_cordic #(
    .STEPS (STEPS_EFF)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fr_valid),
    .ang_i   (fr_ang),
    .side_i  (fr_side),
    .valid_o (co_valid),
    .cos_o   (co_cos),
    .sin_o   (co_sin),
    .side_o  (co_side)
  );

  logic [3:0]          tv_q;
  logic signed [47:0]  pcx_q, psy_q, psx_q, pcy_q;
  sfts_pkg::side_t     s1_q, s2_q, s3_q;
  logic signed [58:0]  sumx_q, sumy_q;
  logic [28:0]         tdx3_q, tdy3_q;
  logic [26:0]         rem3_q;
  logic [46:0]         numx4_q, numy4_q;
  logic [26:0]         rem4_q;
  sfts_pkg::div_side_t dsx4_q, dsy4_q;

  // Touchdown sums, rounding and remaining swing time
  logic signed [58:0] sumx_c, sumy_c, rndx_c, rndy_c;
  assign sumx_c = pcx_q - psy_q + $signed(s1_q.lin_vx);
  assign sumy_c = psx_q + pcy_q + $signed(s1_q.lin_vy);
  assign rndx_c = sumx_q + 59'sd536870912;
  assign rndy_c = sumy_q + 59'sd536870912;

  // Distance to go, magnitude scaled by 2^16 plus half the divisor
  logic signed [29:0] dx_c, dy_c;
  logic [29:0]        magx_c, magy_c;
  assign dx_c   = $signed(tdx3_q) - $signed(s3_q.foot_x);
  assign dy_c   = $signed(tdy3_q) - $signed(s3_q.foot_y);
  assign magx_c = dx_c[29] ? 30'(-dx_c) : 30'(dx_c);
  assign magy_c = dy_c[29] ? 30'(-dy_c) : 30'(dy_c);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tv_q <= '0;
    end else begin
      tv_q <= {tv_q[2:0], co_valid};
    end
  end

  always_ff @(posedge clk_i) begin
    pcx_q <= co_cos * $signed(co_side.stance_x);
    psy_q <= co_sin * $signed(co_side.stance_y);
    psx_q <= co_sin * $signed(co_side.stance_x);
    pcy_q <= co_cos * $signed(co_side.stance_y);
    s1_q  <= co_side;

    sumx_q <= sumx_c;
    sumy_q <= sumy_c;
    s2_q   <= s1_q;

    tdx3_q <= rndx_c[58:30];
    tdy3_q <= rndy_c[58:30];
    rem3_q <= s2_q.phase <= 17'd65536 ?
              cfg_q.swing_cnt * (17'd65536 - s2_q.phase) : 27'd0;
    s3_q   <= s2_q;

    numx4_q     <= 47'({magx_c, 16'h0000}) + 47'(rem3_q[26:1]);
    numy4_q     <= 47'({magy_c, 16'h0000}) + 47'(rem3_q[26:1]);
    rem4_q      <= rem3_q;
    dsx4_q.foot <= s3_q.foot_x;
    dsx4_q.td   <= tdx3_q;
    dsx4_q.neg  <= dx_c[29];
    dsx4_q.zero <= (rem3_q == 27'd0);
    dsx4_q.nz   <= s3_q.nz;
    dsy4_q.foot <= s3_q.foot_y;
    dsy4_q.td   <= tdy3_q;
    dsy4_q.neg  <= dy_c[29];
    dsy4_q.zero <= (rem3_q == 27'd0);
    dsy4_q.nz   <= s3_q.nz;
  end

  logic                dvx_valid, dvy_valid;
  logic [QW:0]         qx, qy;
  sfts_pkg::div_side_t dox, doy;

  sfts_divider u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (tv_q[3]),
    .num_i   (numx4_q),
    .den_i   (rem4_q),
    .side_i  (dsx4_q),
    .valid_o (dvx_valid),
    .quot_o  (qx),
    .side_o  (dox)
  );

  sfts_divider u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (tv_q[3]),
    .num_i   (numy4_q),
    .den_i   (rem4_q),
    .side_i  (dsy4_q),
    .valid_o (dvy_valid),
    .quot_o  (qy),
    .side_o  (doy)
  );

  // Step toward touchdown, or land on it when no swing time is left
  logic signed [29:0] nx_c, ny_c, nz_c;
  logic signed [29:0] qxs, qys;
  assign qxs  = $signed({{(29 - QW){1'b0}}, qx});
  assign qys  = $signed({{(29 - QW){1'b0}}, qy});
  assign nx_c = dox.zero ? 30'($signed(dox.td)) :
                dox.neg ? 30'($signed(dox.foot)) - qxs : 30'($signed(dox.foot)) + qxs;
  assign ny_c = doy.zero ? 30'($signed(doy.td)) :
                doy.neg ? 30'($signed(doy.foot)) - qys : 30'($signed(doy.foot)) + qys;
  assign nz_c = 30'($signed(dox.nz));

  logic        out_v_q;
  logic [15:0] nx_q, ny_q, nz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= dvx_valid & dvy_valid;
    end
  end

  // Saturate and register the result
  always_ff @(posedge clk_i) begin
    nx_q <= sfts_pkg::sat16(nx_c);
    ny_q <= sfts_pkg::sat16(ny_c);
    nz_q <= sfts_pkg::sat16(nz_c);
  end

  assign result_valid_o = out_v_q;
  assign next_x_o       = nx_q;
  assign next_y_o       = ny_q;
  assign next_z_o       = nz_q;

endmodule

>>> sim/swing_foot_trajectory_step_test.sv
// ----------------------------------------------------------------------------
// swing_foot_trajectory_step_test: self-checking bench for the swing foot step
// Sends leg requests with random gaps through several register settings. For
// each request it predicts the touchdown point, the xy step and the lift. It
// checks every result strobe against the oldest prediction.
// ----------------------------------------------------------------------------
module swing_foot_trajectory_step_test;

  localparam int unsigned STEPS     = 14;
  localparam int unsigned LATENCY   = STEPS + 33;
  localparam longint      ONE_PHASE = 65536;
  localparam longint      PI_L      = 64'sd3373259426;
  localparam longint      HALF_PI_L = 64'sd1686629713;
  localparam longint      TWO_PI_L  = 64'sd6746518852;
  localparam longint      GAIN_L    = 64'sd652032874;
  localparam int          CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
  } foot_pos_t;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           start_i = 1'b0;
  logic           busy_o;
  logic           cfg_we_i = 1'b0;
  logic [2:0]     cfg_idx_i = sfts_pkg::CFG_GAIN_LIN;
  logic [15:0]    cfg_wdata_i = '0;
  sfts_pkg::req_t req_q = '0;
  logic           result_valid_o;
  logic [15:0]    next_x_o, next_y_o, next_z_o;

  // shadow copy of the configuration registers
  longint gain_lin_m = 8192, gain_yaw_m = 8192, tick_m = 655;
  longint stance_m = 120, swing_m = 60, lift_m = 287;

  sfts_pkg::req_t pending_reqs[$];
  foot_pos_t      expected_pos[$];
  int        mismatches = 0;
  int        cycles = 0;
  bit        calm = 1'b0;
  int        gap = 0;

  swing_foot_trajectory_step #(.CORDIC_STEPS(STEPS)) dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .swing_phase_i(req_q.phase), .foot_x_i(req_q.foot_x), .foot_y_i(req_q.foot_y),
    .vel_x_i(req_q.vel_x), .vel_y_i(req_q.vel_y), .yaw_cmd_i(req_q.yaw_cmd),
    .body_height_i(req_q.body_height), .stance_x_i(req_q.stance_x),
    .stance_y_i(req_q.stance_y), .result_valid_o, .next_x_o, .next_y_o, .next_z_o
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic longint atan_entry(input int i);
    longint t[20] = '{32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
      32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA,
      32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF,
      32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF,
      32'h000007FF};
    return t[i];
  endfunction

  function automatic longint round_half_up(input longint v, input int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint clamp16(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // rotate the gain vector by angle a (Q.30), fold to the right half plane
  function automatic void rotate_unit(input longint a, output longint c,
                                      output longint s);
    longint r, x, y, z, dx, dy;
    bit flip;
    r = a % TWO_PI_L;
    flip = 1'b0;
    x = GAIN_L;
    y = 0;
    if (r < 0) r += TWO_PI_L;
    if (r >= PI_L) r -= TWO_PI_L;
    if (r > HALF_PI_L) begin
      r -= PI_L;
      flip = 1'b1;
    end else if (r < -HALF_PI_L) begin
      r += PI_L;
      flip = 1'b1;
    end
    z = r;
    for (int i = 0; i < STEPS && i < 20; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= atan_entry(i);
      end else begin
        x += dx;
        y -= dy;
        z += atan_entry(i);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic longint step_to(input longint foot, input longint td,
                                     input longint remaining);
    longint n, mag, q;
    n = (td - foot) * ONE_PHASE;
    mag = n < 0 ? -n : n;
    q = (mag + remaining / 2) / remaining;
    return foot + (n < 0 ? -q : q);
  endfunction

  function automatic foot_pos_t predict_foot_step(input sfts_pkg::req_t r);
    longint phase, scale, lin, ang, c, s, tdx, tdy, remaining, nx, ny, lift;
    longint sx, sy;
    foot_pos_t p;
    phase = r.phase;
    if (phase > ONE_PHASE) phase = ONE_PHASE;
    sx = longint'($signed(r.stance_x));
    sy = longint'($signed(r.stance_y));
    scale = stance_m * tick_m;
    lin = gain_lin_m * scale;
    ang = gain_yaw_m * scale * longint'($signed(r.yaw_cmd));
    rotate_unit(round_half_up(ang, 12), c, s);
    tdx = round_half_up(c * sx - s * sy + lin * longint'($signed(r.vel_x)), 30);
    tdy = round_half_up(s * sx + c * sy + lin * longint'($signed(r.vel_y)), 30);
    remaining = swing_m * (ONE_PHASE - phase);
    if (remaining == 0) begin
      nx = tdx;
      ny = tdy;
    end else begin
      nx = step_to(longint'($signed(r.foot_x)), tdx, remaining);
      ny = step_to(longint'($signed(r.foot_y)), tdy, remaining);
    end
    if (phase < 32768) lift = (phase * lift_m + 16384) >>> 15;
    else lift = ((ONE_PHASE - phase) * lift_m + 16384) >>> 15;
    p.x = 16'(clamp16(nx));
    p.y = 16'(clamp16(ny));
    p.z = 16'(clamp16(lift + longint'($signed(r.body_height))));
    return p;
  endfunction

  // drive requests from the pending queue with random gaps
  always @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      expected_pos.push_back(predict_foot_step(req_q));
    end
    if (gap > 0) begin
      gap <= gap - 1;
      start_i <= 1'b0;
    end else if (pending_reqs.size() > 0 && rst_ni) begin
      req_q <= pending_reqs.pop_front();
      start_i <= 1'b1;
      if (calm) begin
        gap <= 0;
      end else begin
        case ($urandom_range(0, 19))
          0: gap <= $urandom_range(10, 40);
          1, 2, 3, 4: gap <= $urandom_range(1, 3);
          default: gap <= 0;
        endcase
      end
    end else begin
      start_i <= 1'b0;
    end
  end

  // compare each result against the oldest prediction
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (result_valid_o) begin
      if (expected_pos.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10)
          $display("unexpected result x=%h y=%h z=%h", next_x_o, next_y_o, next_z_o);
      end else begin
        foot_pos_t e;
        e = expected_pos.pop_front();
        if (e.x !== next_x_o || e.y !== next_y_o || e.z !== next_z_o) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch expected x=%h y=%h z=%h actual x=%h y=%h z=%h",
                     e.x, e.y, e.z, next_x_o, next_y_o, next_z_o);
        end
      end
    end
    if (cycles >= CYCLE_LIMIT) begin
      $display("swing_foot_trajectory_step_test NOT OK");
      $finish;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input longint v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= 16'(v);
    case (idx)
      sfts_pkg::CFG_GAIN_LIN: gain_lin_m = v & 16'hFFFF;
      sfts_pkg::CFG_GAIN_YAW: gain_yaw_m = v & 16'hFFFF;
      sfts_pkg::CFG_TICK:     tick_m = v & 16'hFFFF;
      sfts_pkg::CFG_STANCE:   stance_m = v & 10'h3FF;
      sfts_pkg::CFG_SWING:    swing_m = v & 10'h3FF;
      sfts_pkg::CFG_LIFT:     lift_m = v & 15'h7FFF;
      default: ;
    endcase
  endtask

  task automatic write_all(input longint gl, input longint gy, input longint tk,
                           input longint st, input longint sw, input longint lf);
    write_reg(sfts_pkg::CFG_GAIN_LIN, gl);
    write_reg(sfts_pkg::CFG_GAIN_YAW, gy);
    write_reg(sfts_pkg::CFG_TICK, tk);
    write_reg(sfts_pkg::CFG_STANCE, st);
    write_reg(sfts_pkg::CFG_SWING, sw);
    write_reg(sfts_pkg::CFG_LIFT, lf);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // hold until every prediction has been checked, then let the pipe drain
  task automatic drain();
    while (pending_reqs.size() > 0 || start_i || expected_pos.size() > 0)
      @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  function automatic logic [15:0] rand_field();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2, 3: return 16'($signed($urandom_range(0, 8191)) - 4096);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic sfts_pkg::req_t rand_req();
    sfts_pkg::req_t r;
    case ($urandom_range(0, 9))
      0: r.phase = 17'($urandom_range(65536, 131071));
      1: r.phase = 17'(65536 - $urandom_range(0, 3));
      default: r.phase = 17'($urandom_range(0, 65536));
    endcase
    r.foot_x = rand_field();
    r.foot_y = rand_field();
    r.vel_x = rand_field();
    r.vel_y = rand_field();
    r.yaw_cmd = rand_field();
    r.body_height = rand_field();
    r.stance_x = rand_field();
    r.stance_y = rand_field();
    return r;
  endfunction

  task automatic push_directed();
    logic [16:0] phases[7] = '{17'd0, 17'd1, 17'd32767, 17'd32768, 17'd65535,
                               17'd65536, 17'h1FFFF};
    logic [15:0] ext[4] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
    sfts_pkg::req_t r;
    foreach (phases[i]) begin
      r = '{phases[i], ext[i % 4], ext[(i + 1) % 4], ext[(i + 2) % 4],
            ext[(i + 3) % 4], ext[i % 4], ext[(i + 1) % 4], ext[(i + 2) % 4],
            ext[(i + 3) % 4]};
      pending_reqs.push_back(r);
    end
    for (int i = 0; i < 4; i++) begin
      r = '{17'd16384, 16'h0000, 16'h0000, ext[i], ext[3 - i], ext[i],
            ext[3 - i], 16'h1000, 16'hF000};
      pending_reqs.push_back(r);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: write_all(8192, 8192, 655, 120, 60, 287);
        1: write_all(65535, 65535, 65535, 1023, 1023, 32767);
        2: write_all(0, 0, 0, 0, 0, 0);
        3: write_all(16384, 65535, 65535, 1023, 1, 32767);
        default: write_all($urandom_range(0, 65535), $urandom_range(0, 65535),
                           $urandom_range(1, 65535), $urandom_range(1, 1023),
                           $urandom_range(0, 1023), $urandom_range(0, 32767));
      endcase
      calm = (ph == 4);
      push_directed();
      for (int i = 0; i < 125; i++) pending_reqs.push_back(rand_req());
      drain();
    end
    if (mismatches == 0 && expected_pos.size() == 0) begin
      $display("swing_foot_trajectory_step_test OK");
    end else begin
      $display("swing_foot_trajectory_step_test NOT OK");
    end
    $finish;
  end

endmodule
